// ----- design/cost_volume_window_argmin_assert.svh -----
// assertion macros shared by the checker of the windowed depth search
// no dependencies; include by bare file name
`ifndef COST_VOLUME_WINDOW_ARGMIN_ASSERT_SVH
`define COST_VOLUME_WINDOW_ARGMIN_ASSERT_SVH

// same-cycle implication, held off during reset
`define CVWA_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define CVWA_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also checks across reset
`define CVWA_ASSERT_RESET(name, clk, ante, cons, msg) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/cvwa_pkg.sv -----
// shared constants, register codes and item types of the windowed depth search
// no dependencies; compiled first
package cvwa_pkg;

  localparam int DEPTH_LEVELS_DEF = 64;

  localparam int COST_W      = 17;
  localparam int PRIOR_W     = 16;
  localparam int SPREAD_W    = 17;
  localparam int WEIGHT_W    = 16;
  localparam int GAIN_W      = 16;
  localparam int LEVEL_OUT_W = 6;
  localparam int ENERGY_W    = 32;

  // fixed point positions
  localparam int FRAC_W      = 8;   // Q8.8 level / weight fraction
  localparam int PRIOR_SHIFT = 16;  // Q8.8 prior to Q8.24
  localparam int RADIUS_FRAC = 24;  // window bounds in Q8.24
  localparam int RADIUS_W    = GAIN_W + SPREAD_W;
  localparam int WIN_W       = RADIUS_W + 2;
  localparam int LOW_W       = 7;

  // power of two so pointers wrap on their own
  localparam int QUEUE_DEPTH = 4;

  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int REG_SEL_BIT = 2;

  localparam logic [WEIGHT_W-1:0] ENERGY_WEIGHT_RST = 16'd256;
  localparam logic [GAIN_W-1:0]   RADIUS_GAIN_RST   = 16'd256;

  typedef enum logic {
    REG_ENERGY_WEIGHT = 1'b0,
    REG_RADIUS_GAIN   = 1'b1
  } cvwa_reg_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] energy_weight;
    logic [GAIN_W-1:0]   radius_gain;
  } cvwa_cfg_t;

  // prior is the pixel's latched prior; spread and pixel_en matter on first only
  typedef struct packed {
    logic [COST_W-1:0]         cost;
    logic                      cost_valid;
    logic signed [PRIOR_W-1:0] prior;
    logic [SPREAD_W-1:0]       spread;
    logic                      pixel_en;
    logic                      first;
    logic                      last;
  } cvwa_item_t;

endpackage

// ----- design/cvwa_in_if.sv -----
// input channel of the windowed depth search: valid/ready plus one cost item
// depends on cvwa_pkg
interface cvwa_in_if;
  logic                                valid;
  logic                                ready;
  logic [cvwa_pkg::COST_W-1:0]         cost;
  logic                                cost_valid;
  logic signed [cvwa_pkg::PRIOR_W-1:0] prior_depth;
  logic                                prior_valid;
  logic [cvwa_pkg::SPREAD_W-1:0]       spread;
  logic                                spread_valid;
  logic                                last;

  modport source (
    output valid, cost, cost_valid, prior_depth, prior_valid, spread, spread_valid, last,
    input  ready
  );

  modport sink (
    input  valid, cost, cost_valid, prior_depth, prior_valid, spread, spread_valid, last,
    output ready
  );
endinterface

// ----- design/cvwa_out_if.sv -----
// result channel of the windowed depth search: valid/ready plus one result item
// depends on cvwa_pkg
interface cvwa_out_if;
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [cvwa_pkg::LEVEL_OUT_W-1:0]  best_level;
  logic [cvwa_pkg::ENERGY_W-1:0]     best_energy;

  modport source (
    output valid, found, best_level, best_energy,
    input  ready
  );

  modport sink (
    input  valid, found, best_level, best_energy,
    output ready
  );
endinterface

// ----- design/cvwa_front.sv -----
// front end: accepts cost items, numbers the depth levels, latches the prior
// depends on cvwa_pkg and cvwa_in_if
module cvwa_front #(
  parameter int  DEPTH_LEVELS = cvwa_pkg::DEPTH_LEVELS_DEF,
  localparam int LW           = $clog2(DEPTH_LEVELS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  cvwa_in_if.sink              in_ch,
  input  logic                 q_full,
  output logic                 push,
  output cvwa_pkg::cvwa_item_t push_item,
  output logic [LW-1:0]        push_level
);

  logic [LW-1:0]                       level_r;
  logic [LW-1:0]                       level_nxt;
  logic signed [cvwa_pkg::PRIOR_W-1:0] prior_r;
  logic                                first;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;
  assign first       = (level_r == '0);
  assign push_level  = level_r;

  always_comb begin
    push_item.cost       = in_ch.cost;
    push_item.cost_valid = in_ch.cost_valid;
    push_item.prior      = first ? in_ch.prior_depth : prior_r;
    push_item.spread     = in_ch.spread;
    push_item.pixel_en   = in_ch.prior_valid && in_ch.spread_valid && (in_ch.spread != '0);
    push_item.first      = first;
    push_item.last       = in_ch.last;
  end

  // counter parks at DEPTH_LEVELS on an overlong pixel
  always_comb begin
    level_nxt = level_r;
    if (in_ch.last) begin
      level_nxt = '0;
    end else if (level_r < LW'(DEPTH_LEVELS)) begin
      level_nxt = level_r + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else if (push) begin
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && first) begin
      prior_r <= in_ch.prior_depth;
    end
  end

endmodule

// ----- design/cvwa_queue.sv -----
// short queue between front and back so each side stalls on its own
// depends on cvwa_pkg for its depth
module cvwa_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         full,
  output logic         empty,
  output logic [W-1:0] pop_data
);

  localparam int QD  = cvwa_pkg::QUEUE_DEPTH;
  localparam int QPW = $clog2(QD);

  logic [W-1:0]   slot_r [QD];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] rd_ptr_r;
  logic [QPW:0]   count_r;
  logic [QPW:0]   count_nxt;

  assign full     = (count_r == (QPW+1)'(QD));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (QPW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (QPW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/cvwa_back.sv -----
// back end: window bounds and energy pipeline, compare-select, result register
// depends on cvwa_pkg and cvwa_out_if
module cvwa_back #(
  parameter int  DEPTH_LEVELS = cvwa_pkg::DEPTH_LEVELS_DEF,
  localparam int LW           = $clog2(DEPTH_LEVELS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cvwa_pkg::cvwa_cfg_t  cfg,
  input  logic                 q_empty,
  input  cvwa_pkg::cvwa_item_t q_item,
  input  logic [LW-1:0]        q_level,
  output logic                 q_pop,
  cvwa_out_if.source           out_ch
);

  localparam int FW    = cvwa_pkg::FRAC_W;
  localparam int WW    = cvwa_pkg::WEIGHT_W;
  localparam int RW    = cvwa_pkg::RADIUS_W;
  localparam int WIN_W = cvwa_pkg::WIN_W;
  localparam int RF    = cvwa_pkg::RADIUS_FRAC;
  localparam int LOW_W = cvwa_pkg::LOW_W;
  localparam int EW    = cvwa_pkg::ENERGY_W;
  localparam int LOUT  = cvwa_pkg::LEVEL_OUT_W;
  localparam int HW    = $clog2(DEPTH_LEVELS);
  localparam int DW    = ((LW + FW) > 15 ? (LW + FW) : 15) + 2;
  localparam int SQW   = 2 * DW - 2;
  localparam int H     = SQW / 2;
  localparam int PPLW  = H + WW;
  localparam int PPHW  = SQW - H + WW;
  localparam int PRODW = SQW + WW;
  localparam int SUMW  = ((PRODW - FW) > cvwa_pkg::COST_W ? (PRODW - FW) : cvwa_pkg::COST_W) + 1;
  localparam int TOPW  = WIN_W - 1 - RF;
  localparam int CW    = (LW > LOW_W) ? LW : LOW_W;
  localparam int NSTG  = 5;

  localparam logic signed [WIN_W-1:0] LVL_ONE    = WIN_W'(1) <<< RF;
  localparam logic signed [WIN_W-1:0] LVL_ONE_M1 = LVL_ONE - WIN_W'(1);

  logic                 adv;
  logic                 stall;
  logic                 fire;

  logic                 stg_v_r    [NSTG];
  cvwa_pkg::cvwa_item_t stg_item_r [NSTG];
  logic [LW-1:0]        stg_lvl_r  [NSTG];

  // stage 1
  logic signed [DW-1:0]    d_s0;
  logic [RW-1:0]           radius_s0;
  logic signed [DW-1:0]    d_s1_r;
  logic [RW-1:0]           radius_s1_r;
  // stage 2
  logic signed [2*DW-1:0]  sq_full;
  logic signed [WIN_W-1:0] center;
  logic signed [WIN_W-1:0] rad_ext;
  logic [SQW-1:0]          sq_s2_r;
  logic signed [WIN_W-1:0] lo_q_s2_r;
  logic signed [WIN_W-1:0] hi_q_s2_r;
  // stage 3
  logic signed [WIN_W-1:0] top_q;
  logic [TOPW-1:0]         top_full;
  logic                    win_off;
  logic [PPLW-1:0]         pp_lo_s3_r;
  logic [PPHW-1:0]         pp_hi_s3_r;
  // window travels with the item from stage 3 to the compare
  logic [LOW_W-1:0]        wlo_stg_r [3];
  logic [HW-1:0]           whi_stg_r [3];
  logic                    wen_stg_r [3];
  // stage 4 and 5
  logic [PRODW-1:0]        prod_s4_r;
  logic [SUMW-1:0]         sum_s4;
  logic [EW-1:0]           energy_s5_r;

  // per-pixel search state
  logic                    pix_en_r;
  logic [LOW_W-1:0]        win_lo_r;
  logic [HW-1:0]           win_hi_r;
  logic                    have_best_r;
  logic [HW-1:0]           best_idx_r;
  logic [EW-1:0]           least_r;

  logic                    cur_en;
  logic [LOW_W-1:0]        cur_lo;
  logic [HW-1:0]           cur_hi;
  logic                    cur_have;
  logic [HW-1:0]           cur_best;
  logic [EW-1:0]           cur_least;
  logic                    in_win;
  logic                    take;
  logic                    have_nxt;
  logic [HW-1:0]           best_nxt;
  logic [EW-1:0]           least_nxt;

  logic                    out_valid_r;
  logic                    found_r;
  logic [LOUT-1:0]         best_level_r;
  logic [EW-1:0]           best_energy_r;

  // a result that cannot leave freezes the whole pipe
  assign stall = stg_v_r[NSTG-1] && stg_item_r[NSTG-1].last && out_valid_r && !out_ch.ready;
  assign adv   = !stall;
  assign fire  = adv && stg_v_r[NSTG-1];
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NSTG; i++) begin
        stg_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      stg_v_r[0] <= !q_empty;
      for (int i = 1; i < NSTG; i++) begin
        stg_v_r[i] <= stg_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg_item_r[0] <= q_item;
      stg_lvl_r[0]  <= q_level;
      for (int i = 1; i < NSTG; i++) begin
        stg_item_r[i] <= stg_item_r[i-1];
        stg_lvl_r[i]  <= stg_lvl_r[i-1];
      end
    end
  end

  // stage 1: level offset from prior, window radius
  assign d_s0 = DW'(q_item.prior) - $signed({{(DW-LW-FW){1'b0}}, q_level, {FW{1'b0}}});
  assign radius_s0 = RW'(cfg.radius_gain) * RW'(q_item.spread);

  // stage 2: squared offset, window edges in Q8.24
  assign sq_full = d_s1_r * d_s1_r;
  assign center  = WIN_W'(stg_item_r[0].prior) <<< cvwa_pkg::PRIOR_SHIFT;
  assign rad_ext = $signed(WIN_W'(radius_s1_r));

  // stage 3: ceil of the upper edge, pixel drops out if the upper edge is at or below level -1
  assign win_off  = (hi_q_s2_r <= -LVL_ONE);
  assign top_q    = hi_q_s2_r + LVL_ONE_M1;
  assign top_full = top_q[WIN_W-2:RF];

  // stage 4 sum feeds stage 5 saturation
  assign sum_s4 = SUMW'(prod_s4_r >> FW) + SUMW'(stg_item_r[3].cost);

  always_ff @(posedge clk) begin
    if (adv) begin
      d_s1_r      <= d_s0;
      radius_s1_r <= radius_s0;

      sq_s2_r     <= sq_full[SQW-1:0];
      lo_q_s2_r   <= center - rad_ext;
      hi_q_s2_r   <= center + rad_ext;

      pp_lo_s3_r  <= PPLW'(sq_s2_r[H-1:0]) * PPLW'(cfg.energy_weight);
      pp_hi_s3_r  <= PPHW'(sq_s2_r[SQW-1:H]) * PPHW'(cfg.energy_weight);
      wen_stg_r[0] <= stg_item_r[1].pixel_en && !win_off;
      if (lo_q_s2_r[WIN_W-1] || lo_q_s2_r == '0) begin
        wlo_stg_r[0] <= '0;
      end else begin
        wlo_stg_r[0] <= lo_q_s2_r[RF+LOW_W-1:RF];
      end
      if (top_full > TOPW'(DEPTH_LEVELS - 1)) begin
        whi_stg_r[0] <= HW'(DEPTH_LEVELS - 1);
      end else begin
        whi_stg_r[0] <= HW'(top_full);
      end
      for (int i = 1; i < 3; i++) begin
        wen_stg_r[i] <= wen_stg_r[i-1];
        wlo_stg_r[i] <= wlo_stg_r[i-1];
        whi_stg_r[i] <= whi_stg_r[i-1];
      end

      prod_s4_r <= (PRODW'(pp_hi_s3_r) << H) + PRODW'(pp_lo_s3_r);

      if (|sum_s4[SUMW-1:EW]) begin
        energy_s5_r <= '1;
      end else begin
        energy_s5_r <= sum_s4[EW-1:0];
      end
    end
  end

  // compare-select: the first item of a pixel starts from a clean slate
  always_comb begin
    cur_en    = stg_item_r[4].first ? wen_stg_r[2] : pix_en_r;
    cur_lo    = stg_item_r[4].first ? wlo_stg_r[2] : win_lo_r;
    cur_hi    = stg_item_r[4].first ? whi_stg_r[2] : win_hi_r;
    cur_have  = stg_item_r[4].first ? 1'b0 : have_best_r;
    cur_best  = best_idx_r;
    cur_least = least_r;
    in_win    = cur_en && stg_item_r[4].cost_valid &&
                (stg_lvl_r[4] < LW'(DEPTH_LEVELS)) &&
                (CW'(stg_lvl_r[4]) >= CW'(cur_lo)) &&
                (CW'(stg_lvl_r[4]) <= CW'(cur_hi));
    take      = in_win && (!cur_have || energy_s5_r < cur_least);
    have_nxt  = cur_have || in_win;
    best_nxt  = take ? stg_lvl_r[4][HW-1:0] : cur_best;
    least_nxt = take ? energy_s5_r : cur_least;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_en_r    <= 1'b0;
      have_best_r <= 1'b0;
    end else if (fire) begin
      pix_en_r    <= cur_en && !stg_item_r[4].last;
      have_best_r <= have_nxt && !stg_item_r[4].last;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      win_lo_r   <= cur_lo;
      win_hi_r   <= cur_hi;
      best_idx_r <= best_nxt;
      least_r    <= least_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && stg_item_r[4].last) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && stg_item_r[4].last) begin
      found_r       <= have_nxt;
      best_level_r  <= have_nxt ? LOUT'(best_nxt) : '0;
      best_energy_r <= have_nxt ? least_nxt : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = found_r;
  assign out_ch.best_level  = best_level_r;
  assign out_ch.best_energy = best_energy_r;

endmodule

// ----- design/cost_volume_window_argmin.sv -----
// Windowed exhaustive depth search over a cost volume, one pixel at a time.
// Input channel in_ch: one item per depth level, level 0 first, last marks the
// pixel's final level; the first item also carries prior depth, spread and
// their valid flags. Result channel out_ch: one item per pixel, on its last
// level: found, best level (first strict minimum) and saturated best energy.
// Configuration over APB: energy_weight at 0x0, radius_gain at 0x4, both Q8.8;
// the user writes them only while the block is idle (not enforced); pready is always high.
// Throughput: one item per cycle sustained while out_ch does not stall. A
// result passes from the edge that accepts the pixel's last item through the
// 4-entry input queue and five pipeline stages (window radius and level
// offset, square and window edges, weight products, product sum, saturated
// add of the cost); then the compare-select loads the output register.
// When out_ch stalls, the result holds in the output register and the pipe
// keeps running until the next result reaches the compare stage; then the
// pipe freezes, the queue fills and in_ch.ready drops.
// Reset (synchronous, rst_n low) empties queue and pipe, restarts the level
// count at 0 and sets both weights to 1.0.
// depends on cvwa_pkg, cvwa_in_if, cvwa_out_if, cvwa_front, cvwa_queue, cvwa_back
module cost_volume_window_argmin #(
  parameter int DEPTH_LEVELS = cvwa_pkg::DEPTH_LEVELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  cvwa_in_if.sink                      in_ch,
  cvwa_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cvwa_pkg::PADDR_W-1:0] paddr,
  input  logic [cvwa_pkg::PDATA_W-1:0] pwdata,
  output logic [cvwa_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  localparam int LW  = $clog2(DEPTH_LEVELS + 1);
  localparam int IW  = $bits(cvwa_pkg::cvwa_item_t);
  localparam int QW  = IW + LW;
  localparam int PDW = cvwa_pkg::PDATA_W;
  localparam int WW  = cvwa_pkg::WEIGHT_W;
  localparam int GW  = cvwa_pkg::GAIN_W;

  logic [WW-1:0]        energy_weight_r;
  logic [GW-1:0]        radius_gain_r;
  cvwa_pkg::cvwa_reg_t  reg_sel;
  logic                 cfg_wr;
  cvwa_pkg::cvwa_cfg_t  cfg;

  logic                 push;
  cvwa_pkg::cvwa_item_t push_item;
  logic [LW-1:0]        push_level;
  logic                 q_full;
  logic                 q_empty;
  logic                 q_pop;
  logic [QW-1:0]        q_data;
  cvwa_pkg::cvwa_item_t q_item;
  logic [LW-1:0]        q_level;

  assign pready  = 1'b1;
  assign reg_sel = cvwa_pkg::cvwa_reg_t'(paddr[cvwa_pkg::REG_SEL_BIT]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      energy_weight_r <= cvwa_pkg::ENERGY_WEIGHT_RST;
      radius_gain_r   <= cvwa_pkg::RADIUS_GAIN_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        cvwa_pkg::REG_ENERGY_WEIGHT: energy_weight_r <= pwdata[WW-1:0];
        cvwa_pkg::REG_RADIUS_GAIN:   radius_gain_r   <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      cvwa_pkg::REG_ENERGY_WEIGHT: prdata = PDW'(energy_weight_r);
      cvwa_pkg::REG_RADIUS_GAIN:   prdata = PDW'(radius_gain_r);
      default:                     prdata = '0;
    endcase
  end

  assign cfg.energy_weight = energy_weight_r;
  assign cfg.radius_gain   = radius_gain_r;

  cvwa_front #(
    .DEPTH_LEVELS (DEPTH_LEVELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item),
    .push_level (push_level)
  );

  cvwa_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({push_item, push_level}),
    .pop       (q_pop),
    .full      (q_full),
    .empty     (q_empty),
    .pop_data  (q_data)
  );

  assign q_item  = cvwa_pkg::cvwa_item_t'(q_data[QW-1:LW]);
  assign q_level = q_data[LW-1:0];

  cvwa_back #(
    .DEPTH_LEVELS (DEPTH_LEVELS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .q_empty (q_empty),
    .q_item  (q_item),
    .q_level (q_level),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- design/cvwa_checker.sv -----
// port-level checks of the windowed depth search, bound to its top level
// depends on cvwa_pkg and cost_volume_window_argmin_assert.svh
`include "cost_volume_window_argmin_assert.svh"

module cvwa_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic                             found,
  input logic [cvwa_pkg::LEVEL_OUT_W-1:0] best_level,
  input logic [cvwa_pkg::ENERGY_W-1:0]    best_energy,
  input logic                             psel,
  input logic                             penable,
  input logic                             pwrite,
  input logic                             pready,
  input logic [cvwa_pkg::PADDR_W-1:0]     paddr,
  input logic [cvwa_pkg::PDATA_W-1:0]     pwdata,
  input logic [cvwa_pkg::PDATA_W-1:0]     prdata
);

  localparam int RW = cvwa_pkg::WEIGHT_W;
  localparam int SB = cvwa_pkg::REG_SEL_BIT;

  // reset leaves an empty queue and no pending result
  `CVWA_ASSERT_RESET(a_reset_state, clk, !rst_n, in_ready && !out_valid, "bad state after reset")

  `CVWA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // a pixel with nothing in its window reports zeros
  `CVWA_ASSERT_IMPL(a_empty_zero, clk, rst_n, out_valid && !found, best_level == 0 && best_energy == 0, "nonzero result without find")

  // a written register reads back on the next cycle at the same address
  `CVWA_ASSERT_NEXT(a_reg_readback, clk, rst_n, psel && penable && pwrite && pready, paddr[SB] != $past(paddr[SB]) || (prdata[RW-1:0] == $past(pwdata[RW-1:0]) && (prdata >> RW) == 0), "register readback mismatch")

endmodule

bind cost_volume_window_argmin cvwa_checker u_cvwa_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .found       (out_ch.found),
  .best_level  (out_ch.best_level),
  .best_energy (out_ch.best_energy),
  .psel        (psel),
  .penable     (penable),
  .pwrite      (pwrite),
  .pready      (pready),
  .paddr       (paddr),
  .pwdata      (pwdata),
  .prdata      (prdata)
);
